FILE: hdl/smc4_pkg.sv
// Shared types, constants and helper functions for the four-axis sliding-mode controller.
// No dependencies; every other file of the block imports this package.

package smc4_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_TAB_LEN    = 24;

    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int PULSE_W   = 11;

    // Shared multiplier operand and product widths.
    localparam int MUL_AW = 34;
    localparam int MUL_BW = 18;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int SAT_W  = PROD_W + 1;

    // Constant divider: the numerator magnitude is taken in 14-bit chunks. Each
    // quotient digit comes from a reciprocal product and is fixed up by one
    // compare and subtract, so each chunk has an estimate step and a correction step.
    localparam int DIV_W      = 42;
    localparam int DEN_W      = 11;
    localparam int DIG_W      = 14;
    localparam int DIV_CHUNKS = DIV_W / DIG_W;
    localparam int DIV_STEPS  = 2 * DIV_CHUNKS;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int PART_W     = DEN_W + DIG_W;
    localparam int RCP_W      = 21;

    // CORDIC vector and angle widths.
    localparam int CORD_W = 36;
    localparam int ANG_W  = 20;
    localparam int CI_W   = $clog2(ANGLE_TAB_LEN);

    // Integer square root.
    localparam int SQ_W     = 35;
    localparam int SQ_STEPS = 17;
    localparam int SQC_W    = $clog2(SQ_STEPS);

    localparam int ARG_W  = 18;
    localparam int PW_W   = 25;
    localparam int CLMP_W = 27;

    localparam logic [DEN_W-1:0] DEN_HEIGHT = 11'd1000;
    localparam logic [DEN_W-1:0] DEN_RATE   = 11'd26;
    localparam logic [DEN_W-1:0] DEN_ASIN   = 11'd1962;

    // Reciprocals rounded down, scaled by 2^PART_W.
    localparam logic [RCP_W-1:0] RCP_HEIGHT = RCP_W'((64'd1 << PART_W) / 64'(DEN_HEIGHT));
    localparam logic [RCP_W-1:0] RCP_RATE   = RCP_W'((64'd1 << PART_W) / 64'(DEN_RATE));
    localparam logic [RCP_W-1:0] RCP_ASIN   = RCP_W'((64'd1 << PART_W) / 64'(DEN_ASIN));

    localparam int RATE_MUL      = 40;
    localparam int RATE_BIAS     = 13;
    localparam int ASIN_MUL      = 200;
    localparam int ASIN_BIAS     = 981;
    localparam int HEIGHT_BIAS   = 500;
    localparam int TWO_OVER_PI   = 41722;
    localparam int ONE_Q16       = 65536;
    localparam int PLANAR_SCALE  = 150;
    localparam int HEADING_SCALE = 90;

    localparam int PULSE_MID     = 1500;
    localparam int PULSE_LO      = 1300;
    localparam int PULSE_HI      = 1700;
    localparam int YAW_LO        = 1400;
    localparam int YAW_HI        = 1600;
    localparam int THR_HI        = 1550;
    localparam int MODE_LOITER   = 1420;

    localparam logic [CFG_W-1:0] ALT_TARGET_RST = 17'd7000;
    localparam logic signed [15:0] LAM_PLANAR_RST  = 16'sd3686;
    localparam logic signed [15:0] LAM_HEIGHT_RST  = 16'sd2048;
    localparam logic signed [15:0] LAM_HEADING_RST = 16'sd410;
    localparam logic signed [15:0] GAIN_PLANAR_RST  = -16'sd4096;
    localparam logic signed [15:0] GAIN_HEIGHT_RST  = -16'sd3277;
    localparam logic signed [15:0] GAIN_HEADING_RST = -16'sd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALT_TARGET,
        REG_LAMBDA_PLANAR,
        REG_LAMBDA_HEIGHT,
        REG_LAMBDA_HEADING,
        REG_GAIN_PLANAR,
        REG_GAIN_HEIGHT,
        REG_GAIN_HEADING
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AX_HEIGHT,
        AX_Y,
        AX_X,
        AX_HEADING
    } axis_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EZ,
        S_EZ_SAVE,
        S_AX_START,
        S_RATE_MUL,
        S_RATE_DIV,
        S_RATE_SAVE,
        S_S_SUM,
        S_LR,
        S_ARG_MUL,
        S_ARG_DIV,
        S_ARG_SAVE,
        S_SQ_MUL,
        S_SQRT_CALL,
        S_ASIN_CALL,
        S_ASIN_SAVE,
        S_SW_CALL,
        S_SW_NORM,
        S_SW_GAIN,
        S_SW_GMUL,
        S_U,
        S_PW_MUL,
        S_PW_SAVE,
        S_FINISH,
        S_DIV,
        S_CORDIC,
        S_ISQRT
    } state_t;

    // Arctangent of 2^-i in Q16.16 radians.
    function automatic logic [15:0] angle_entry(input logic [CI_W-1:0] i);
        logic [15:0] a;
        begin
            case (i)
                5'd0:    a = 16'd51472;
                5'd1:    a = 16'd30386;
                5'd2:    a = 16'd16055;
                5'd3:    a = 16'd8150;
                5'd4:    a = 16'd4091;
                5'd5:    a = 16'd2047;
                5'd6:    a = 16'd1024;
                5'd7:    a = 16'd512;
                5'd8:    a = 16'd256;
                5'd9:    a = 16'd128;
                5'd10:   a = 16'd64;
                5'd11:   a = 16'd32;
                5'd12:   a = 16'd16;
                5'd13:   a = 16'd8;
                5'd14:   a = 16'd4;
                5'd15:   a = 16'd2;
                5'd16:   a = 16'd1;
                default: a = 16'd0;
            endcase
            return a;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        begin
            if (v > SAT_W'(64'sd2147483647))
                return 32'sh7FFF_FFFF;
            else if (v < -SAT_W'(64'sd2147483648))
                return 32'sh8000_0000;
            else
                return v[31:0];
        end
    endfunction

    // Q4.12 product back to Q16.16: round half up, then saturate.
    function automatic logic signed [31:0] mq12(input logic signed [PROD_W-1:0] p);
        logic signed [SAT_W-1:0] t;
        begin
            t = (SAT_W'(p) + SAT_W'(2048)) >>> 12;
            return sat32(t);
        end
    endfunction

    function automatic logic [PULSE_W-1:0] clamp_pw(input logic signed [CLMP_W-1:0] v,
                                                    input int lo, input int hi);
        begin
            if (v < CLMP_W'(lo))
                return PULSE_W'(lo);
            else if (v > CLMP_W'(hi))
                return PULSE_W'(hi);
            else
                return v[PULSE_W-1:0];
        end
    endfunction

endpackage

FILE: hdl/sliding_mode_four_axis_controller.sv
// One word is in work at a time; in_ready is high only when the sequencer is idle, so the
// next word is taken only once the previous result has gone into the output register. The
// cost is set by the shared CORDIC (six passes) and the shared constant divider (seven passes).
// Reset (rst_n low, asynchronous) restores the register defaults and clears the stored errors.
// Depends on smc4_pkg.
module sliding_mode_four_axis_controller #(
    parameter int CORDIC_STEPS = smc4_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [smc4_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [smc4_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [17:0]                     altitude_mm,
    input  logic signed [15:0]                     lateral_x_error,
    input  logic signed [15:0]                     lateral_y_error,
    input  logic signed [15:0]                     heading_error,
    input  logic                                   target_seen,
    input  logic                                   drive_enable,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [smc4_pkg::PULSE_W-1:0]           roll_pulse,
    output logic [smc4_pkg::PULSE_W-1:0]           pitch_pulse,
    output logic [smc4_pkg::PULSE_W-1:0]           throttle_sent,
    output logic [smc4_pkg::PULSE_W-1:0]           yaw_pulse,
    output logic [smc4_pkg::PULSE_W-1:0]           mode_pulse,
    output logic [smc4_pkg::PULSE_W-1:0]           throttle_computed
);
    import smc4_pkg::*;

    // Table entries beyond the last one are zero, so longer runs are capped.
    localparam int NSTEPS = (CORDIC_STEPS > ANGLE_TAB_LEN) ? ANGLE_TAB_LEN : CORDIC_STEPS;

    // Configuration registers.
    logic [CFG_W-1:0]   alt_tgt_reg;
    logic signed [15:0] lam_pl_reg, lam_ht_reg, lam_hd_reg;
    logic signed [15:0] gain_pl_reg, gain_ht_reg, gain_hd_reg;

    // Sequencer.
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    axis_t  axis_reg;

    // Latched input word.
    logic signed [17:0] alt_reg;
    logic signed [15:0] ex_reg, ey_reg, eh_reg;
    logic               seen_reg, en_reg;

    // Per-axis working values, Q16.16 except the integer pulse offsets in pw_reg.
    logic signed [31:0] ez_reg, e_reg, r_reg, s_reg, lr_reg, ueq_reg;
    logic signed [ARG_W-1:0] arg_reg;
    logic signed [ANG_W-1:0] nrm_reg;
    logic signed [31:0] prev_reg [4];
    logic signed [31:0] u_reg [4];
    logic signed [PW_W-1:0] pw_reg [4];

    // Shared multiplier.
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_reg;

    // Shared constant divider.
    logic [DIV_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg, den_reg;
    logic [RCP_W-1:0]  rcp_reg;
    logic [DIG_W-1:0]  dq_reg;
    logic              dneg_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic signed [DIV_W-1:0] div_num;
    logic [DEN_W-1:0]  div_den;
    logic [RCP_W-1:0]  div_rcp;
    logic [PART_W-1:0] div_part, rem_try;
    logic [PART_W+RCP_W-1:0] rcp_prod;
    logic              rem_hi;
    logic signed [DIV_W:0]   div_res;
    logic signed [31:0]      div_sat;

    // Shared CORDIC.
    logic signed [CORD_W-1:0] cx_reg, cy_reg, cx_sh, cy_sh;
    logic signed [ANG_W-1:0]  cz_reg, c_ang;
    logic [CI_W-1:0]          ci_reg;

    // Integer square root.
    logic [SQ_W-1:0]  sqn_reg, sqr_reg, sqb_reg, sq_trial;
    logic [SQC_W-1:0] sqc_reg;

    // Output register.
    logic                out_valid_reg;
    logic [PULSE_W-1:0]  roll_reg, pitch_reg, thr_sent_reg, yaw_reg, mode_reg, thr_comp_reg;

    logic signed [15:0] lam_sel, gain_sel;
    logic signed [31:0] e_sel, prev_sel;
    logic               planar;
    logic signed [18:0] height_diff;
    logic signed [31:0] lam_prod;
    logic               out_free;

    // ------------------------------------------------------------------
    // Axis selection. Height uses the altitude gains, x and y share the
    // planar gains, heading has its own.
    // ------------------------------------------------------------------
    always_comb
    begin
        planar = (axis_reg == AX_X) || (axis_reg == AX_Y);
        case (axis_reg)
            AX_HEIGHT:
            begin
                lam_sel  = lam_ht_reg;
                gain_sel = gain_ht_reg;
                e_sel    = ez_reg;
            end
            AX_Y:
            begin
                lam_sel  = lam_pl_reg;
                gain_sel = gain_pl_reg;
                e_sel    = $signed({{8{ey_reg[15]}}, ey_reg, 8'd0});
            end
            AX_X:
            begin
                lam_sel  = lam_pl_reg;
                gain_sel = gain_pl_reg;
                e_sel    = $signed({{8{ex_reg[15]}}, ex_reg, 8'd0});
            end
            default:
            begin
                lam_sel  = lam_hd_reg;
                gain_sel = gain_hd_reg;
                e_sel    = $signed({{8{eh_reg[15]}}, eh_reg, 8'd0});
            end
        endcase
        prev_sel = prev_reg[axis_reg];
    end

    assign height_diff = $signed({2'b00, alt_tgt_reg}) - 19'(alt_reg);
    assign lam_prod    = mq12(prod_reg);
    assign out_free    = !out_valid_reg || out_ready;

    // Divider result with the sign restored; floor rounding was folded into
    // the magnitude when the division was started.
    assign div_res = dneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign div_sat = sat32(SAT_W'(div_res));

    // The running remainder and the next chunk form the partial dividend. The
    // reciprocal product gives its quotient digit or one less; the remainder
    // compare decides which.
    assign div_part = {rem_reg, quo_reg[DIV_W-1 -: DIG_W]};
    assign rcp_prod = div_part * rcp_reg;
    assign rem_try  = div_part - PART_W'(dq_reg) * PART_W'(den_reg);
    assign rem_hi   = rem_try >= PART_W'(den_reg);

    assign cx_sh = cx_reg >>> ci_reg;
    assign cy_sh = cy_reg >>> ci_reg;
    assign c_ang = $signed({{(ANG_W-16){1'b0}}, angle_entry(ci_reg)});

    assign sq_trial = sqr_reg + sqb_reg;

    // ------------------------------------------------------------------
    // Next state. Divider, CORDIC and square root are shared subroutines:
    // the calling state loads ret_reg and the unit returns there.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_EZ;
            S_EZ:
            begin
                state_next = S_DIV;
                ret_next   = S_EZ_SAVE;
            end
            S_EZ_SAVE:   state_next = S_AX_START;
            S_AX_START:  state_next = S_RATE_MUL;
            S_RATE_MUL:  state_next = S_RATE_DIV;
            S_RATE_DIV:
            begin
                state_next = S_DIV;
                ret_next   = S_RATE_SAVE;
            end
            S_RATE_SAVE: state_next = S_S_SUM;
            S_S_SUM:     state_next = S_LR;
            S_LR:        state_next = planar ? S_ARG_MUL : S_SW_CALL;
            S_ARG_MUL:   state_next = S_ARG_DIV;
            S_ARG_DIV:
            begin
                state_next = S_DIV;
                ret_next   = S_ARG_SAVE;
            end
            S_ARG_SAVE:  state_next = S_SQ_MUL;
            S_SQ_MUL:    state_next = S_SQRT_CALL;
            S_SQRT_CALL:
            begin
                state_next = S_ISQRT;
                ret_next   = S_ASIN_CALL;
            end
            S_ASIN_CALL:
            begin
                state_next = S_CORDIC;
                ret_next   = S_ASIN_SAVE;
            end
            S_ASIN_SAVE: state_next = S_SW_CALL;
            S_SW_CALL:
            begin
                state_next = S_CORDIC;
                ret_next   = S_SW_NORM;
            end
            S_SW_NORM:   state_next = S_SW_GAIN;
            S_SW_GAIN:   state_next = S_SW_GMUL;
            S_SW_GMUL:   state_next = S_U;
            S_U:         state_next = (axis_reg == AX_HEADING) ? S_PW_MUL : S_AX_START;
            S_PW_MUL:    state_next = S_PW_SAVE;
            S_PW_SAVE:   state_next = (axis_reg == AX_HEADING) ? S_FINISH : S_PW_MUL;
            S_FINISH:    if (out_free) state_next = S_IDLE;
            S_DIV:       if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) state_next = ret_reg;
            S_CORDIC:    if (ci_reg == CI_W'(NSTEPS - 1)) state_next = ret_reg;
            S_ISQRT:     if (sqc_reg == SQC_W'(SQ_STEPS - 1)) state_next = ret_reg;
            default:     state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs: handshake, multiplier operands, divider operands.
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        mul_a    = '0;
        mul_b    = '0;
        div_num  = '0;
        div_den  = DEN_RATE;
        div_rcp  = RCP_RATE;
        case (state_reg)
            S_EZ:
            begin
                div_num = (DIV_W'(height_diff) <<< 16) + DIV_W'(HEIGHT_BIAS);
                div_den = DEN_HEIGHT;
                div_rcp = RCP_HEIGHT;
            end
            S_RATE_MUL:
            begin
                mul_a = MUL_AW'(e_reg) - MUL_AW'(prev_sel);
                mul_b = MUL_BW'(RATE_MUL);
            end
            S_RATE_DIV:
            begin
                div_num = DIV_W'(prod_reg + PROD_W'(RATE_BIAS));
                div_den = DEN_RATE;
                div_rcp = RCP_RATE;
            end
            S_RATE_SAVE:
            begin
                mul_a = MUL_AW'(e_reg);
                mul_b = MUL_BW'(lam_sel);
            end
            S_S_SUM:
            begin
                mul_a = MUL_AW'(r_reg);
                mul_b = MUL_BW'(lam_sel);
            end
            S_ARG_MUL:
            begin
                mul_a = -MUL_AW'(lr_reg);
                mul_b = MUL_BW'(ASIN_MUL);
            end
            S_ARG_DIV:
            begin
                div_num = DIV_W'(prod_reg + PROD_W'(ASIN_BIAS));
                div_den = DEN_ASIN;
                div_rcp = RCP_ASIN;
            end
            S_SQ_MUL:
            begin
                mul_a = MUL_AW'(arg_reg);
                mul_b = MUL_BW'(arg_reg);
            end
            S_SW_NORM:
            begin
                mul_a = MUL_AW'(cz_reg);
                mul_b = MUL_BW'(TWO_OVER_PI);
            end
            S_SW_GMUL:
            begin
                mul_a = MUL_AW'(nrm_reg);
                mul_b = MUL_BW'(gain_sel);
            end
            S_PW_MUL:
            begin
                mul_a = MUL_AW'(u_reg[axis_reg]);
                mul_b = (axis_reg == AX_HEADING) ? MUL_BW'(HEADING_SCALE)
                                                 : MUL_BW'(PLANAR_SCALE);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            axis_reg      <= AX_HEIGHT;
            out_valid_reg <= 1'b0;
            alt_tgt_reg   <= ALT_TARGET_RST;
            lam_pl_reg    <= LAM_PLANAR_RST;
            lam_ht_reg    <= LAM_HEIGHT_RST;
            lam_hd_reg    <= LAM_HEADING_RST;
            gain_pl_reg   <= GAIN_PLANAR_RST;
            gain_ht_reg   <= GAIN_HEIGHT_RST;
            gain_hd_reg   <= GAIN_HEADING_RST;
            for (int k = 0; k < 4; k++)
            begin
                prev_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;

            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ALT_TARGET:     alt_tgt_reg <= cfg_data;
                    REG_LAMBDA_PLANAR:  lam_pl_reg  <= cfg_data[15:0];
                    REG_LAMBDA_HEIGHT:  lam_ht_reg  <= cfg_data[15:0];
                    REG_LAMBDA_HEADING: lam_hd_reg  <= cfg_data[15:0];
                    REG_GAIN_PLANAR:    gain_pl_reg <= cfg_data[15:0];
                    REG_GAIN_HEIGHT:    gain_ht_reg <= cfg_data[15:0];
                    REG_GAIN_HEADING:   gain_hd_reg <= cfg_data[15:0];
                    default:            ;
                endcase
            end

            case (state_reg)
                S_EZ_SAVE: axis_reg <= AX_HEIGHT;
                S_U:
                begin
                    prev_reg[axis_reg] <= e_reg;
                    axis_reg <= axis_t'(axis_reg + 2'd1);
                end
                S_PW_SAVE: axis_reg <= axis_t'(axis_reg + 2'd1);
                default:   ;
            endcase

            if (state_reg == S_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    alt_reg  <= altitude_mm;
                    ex_reg   <= lateral_x_error;
                    ey_reg   <= lateral_y_error;
                    eh_reg   <= heading_error;
                    seen_reg <= target_seen;
                    en_reg   <= drive_enable;
                end
            end
            S_EZ, S_RATE_DIV, S_ARG_DIV:
            begin
                // Floor division of a negative value divides ceil of the magnitude.
                dneg_reg <= div_num[DIV_W-1];
                quo_reg  <= div_num[DIV_W-1] ? DIV_W'(-div_num + DIV_W'(div_den) - DIV_W'(1))
                                             : DIV_W'(div_num);
                den_reg  <= div_den;
                rcp_reg  <= div_rcp;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            S_DIV:
            begin
                // Even steps estimate the digit, odd steps correct it and shift it in.
                if (!dcnt_reg[0])
                begin
                    dq_reg <= rcp_prod[PART_W +: DIG_W];
                end
                else
                begin
                    rem_reg <= rem_hi ? DEN_W'(rem_try - PART_W'(den_reg))
                                      : rem_try[DEN_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-DIG_W-1:0], dq_reg + DIG_W'(rem_hi)};
                end
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            S_EZ_SAVE:   ez_reg <= div_sat;
            S_AX_START:  e_reg  <= e_sel;
            S_RATE_SAVE: r_reg  <= div_sat;
            S_S_SUM:     s_reg  <= sat32(SAT_W'(r_reg) + SAT_W'(lam_prod));
            S_LR:
            begin
                lr_reg  <= lam_prod;
                ueq_reg <= sat32(SAT_W'(e_reg) - SAT_W'(lam_prod));
            end
            S_ARG_SAVE:
            begin
                if (div_res > (DIV_W + 1)'(ONE_Q16))
                    arg_reg <= ARG_W'(ONE_Q16);
                else if (div_res < -(DIV_W + 1)'(ONE_Q16))
                    arg_reg <= -ARG_W'(ONE_Q16);
                else
                    arg_reg <= ARG_W'(div_res);
            end
            S_SQRT_CALL:
            begin
                sqn_reg <= SQ_W'(64'h1_0000_0000) - SQ_W'(prod_reg[32:0]);
                sqr_reg <= '0;
                sqb_reg <= SQ_W'(64'h1_0000_0000);
                sqc_reg <= '0;
            end
            S_ISQRT:
            begin
                if (sqn_reg >= sq_trial)
                begin
                    sqn_reg <= sqn_reg - sq_trial;
                    sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                end
                else
                begin
                    sqr_reg <= sqr_reg >> 1;
                end
                sqb_reg <= sqb_reg >> 2;
                sqc_reg <= sqc_reg + SQC_W'(1);
            end
            S_ASIN_CALL:
            begin
                // asin(a) = atan2(a, sqrt(1 - a*a)).
                cx_reg <= $signed({1'b0, sqr_reg});
                cy_reg <= CORD_W'(arg_reg);
                cz_reg <= '0;
                ci_reg <= '0;
            end
            S_ASIN_SAVE: ueq_reg <= 32'(cz_reg);
            S_SW_CALL:
            begin
                cx_reg <= CORD_W'(ONE_Q16);
                cy_reg <= CORD_W'(s_reg);
                cz_reg <= '0;
                ci_reg <= '0;
            end
            S_CORDIC:
            begin
                if (!cy_reg[CORD_W-1])
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + c_ang;
                end
                else
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - c_ang;
                end
                ci_reg <= ci_reg + CI_W'(1);
            end
            S_SW_GAIN:   nrm_reg <= ANG_W'((SAT_W'(prod_reg) + SAT_W'(32768)) >>> 16);
            S_U:         u_reg[axis_reg] <= sat32(SAT_W'(ueq_reg) - SAT_W'(lam_prod));
            S_PW_SAVE:   pw_reg[axis_reg] <= PW_W'((SAT_W'(prod_reg) + SAT_W'(32768)) >>> 16);
            S_FINISH:
            begin
                if (out_free)
                begin
                    thr_comp_reg <= clamp_pw(CLMP_W'(PULSE_MID) + CLMP_W'(pw_reg[AX_HEIGHT]),
                                             PULSE_LO, THR_HI);
                    if (en_reg)
                    begin
                        roll_reg  <= seen_reg ?
                                     clamp_pw(CLMP_W'(PULSE_MID) - CLMP_W'(pw_reg[AX_X]),
                                              PULSE_LO, PULSE_HI) : PULSE_W'(PULSE_MID);
                        pitch_reg <= seen_reg ?
                                     clamp_pw(CLMP_W'(PULSE_MID) + CLMP_W'(pw_reg[AX_Y]),
                                              PULSE_LO, PULSE_HI) : PULSE_W'(PULSE_MID);
                        yaw_reg   <= clamp_pw(CLMP_W'(PULSE_MID) - CLMP_W'(pw_reg[AX_HEADING]),
                                              YAW_LO, YAW_HI);
                        thr_sent_reg <= PULSE_W'(PULSE_MID);
                        mode_reg     <= PULSE_W'(MODE_LOITER);
                    end
                    else
                    begin
                        roll_reg     <= '0;
                        pitch_reg    <= '0;
                        yaw_reg      <= '0;
                        thr_sent_reg <= '0;
                        mode_reg     <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign roll_pulse        = roll_reg;
    assign pitch_pulse       = pitch_reg;
    assign throttle_sent     = thr_sent_reg;
    assign yaw_pulse         = yaw_reg;
    assign mode_pulse        = mode_reg;
    assign throttle_computed = thr_comp_reg;

endmodule

FILE: hdl/smc4_checker.sv
// Port-level checks for the four-axis sliding-mode controller, bound to its top level.
// Depends on smc4_pkg and sliding_mode_four_axis_controller.
module smc4_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [smc4_pkg::PULSE_W-1:0]  roll_pulse,
    input logic [smc4_pkg::PULSE_W-1:0]  pitch_pulse,
    input logic [smc4_pkg::PULSE_W-1:0]  throttle_sent,
    input logic [smc4_pkg::PULSE_W-1:0]  yaw_pulse,
    input logic [smc4_pkg::PULSE_W-1:0]  mode_pulse,
    input logic [smc4_pkg::PULSE_W-1:0]  throttle_computed
);
    import smc4_pkg::*;

    // Once a word is taken the block is busy and in_ready goes low.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is still in work");

    // A held result keeps its value in roll, yaw and computed throttle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll_pulse) && $stable(yaw_pulse)
            && $stable(throttle_computed))
        else $error("stalled result changed");

    // The mode channel is loiter when driving and zero when stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mode_pulse == PULSE_W'(MODE_LOITER)) || (mode_pulse == '0))
        else $error("mode channel out of set");

    // The mode, roll, pitch and sent throttle channels go to zero together.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((mode_pulse == '0) == (roll_pulse == '0))
            && ((mode_pulse == '0) == (throttle_sent == '0))
            && ((mode_pulse == '0) == (pitch_pulse == '0)))
        else $error("stop channels disagree");

    // The monitored throttle is always inside its clamp window.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> throttle_computed >= PULSE_W'(PULSE_LO)
            && throttle_computed <= PULSE_W'(THR_HI))
        else $error("computed throttle outside clamp range");

endmodule

bind sliding_mode_four_axis_controller smc4_checker u_smc4_checker (.*);

FILE: dv/tb_sliding_mode_four_axis_controller.sv
// Testbench for the four-axis sliding-mode controller: random and directed words with a
// bit-exact fixed-point predictor and an in-order scoreboard. Depends on smc4_pkg and the RTL.
`timescale 1ns / 1ps

// One expected or observed result word: the six pulse channels.
typedef struct packed {
    logic [10:0] roll;
    logic [10:0] pitch;
    logic [10:0] thr_sent;
    logic [10:0] yaw;
    logic [10:0] mode;
    logic [10:0] thr_calc;
} pulse_word_t;

class pulse_scoreboard;
    pulse_word_t pending_pulses[$];
    int          errors;
    // Register copy and stored errors, all held in Q16.16 or the native register scale.
    longint      alt_target, lam_pl, lam_ht, lam_hd, k_pl, k_ht, k_hd;
    longint      last_x, last_y, last_z, last_h;

    function void reset_state();
        alt_target = 7000;
        lam_pl = 3686; lam_ht = 2048; lam_hd = 410;
        k_pl = -4096; k_ht = -3277; k_hd = -2048;
        last_x = 0; last_y = 0; last_z = 0; last_h = 0;
        errors = 0;
    endfunction

    function void write_reg(smc4_pkg::cfg_reg_t idx, logic [16:0] val);
        longint sv;
        sv = longint'(signed'(val[15:0]));
        case (idx)
            smc4_pkg::REG_ALT_TARGET:     alt_target = longint'(val);
            smc4_pkg::REG_LAMBDA_PLANAR:  lam_pl = sv;
            smc4_pkg::REG_LAMBDA_HEIGHT:  lam_ht = sv;
            smc4_pkg::REG_LAMBDA_HEADING: lam_hd = sv;
            smc4_pkg::REG_GAIN_PLANAR:    k_pl = sv;
            smc4_pkg::REG_GAIN_HEIGHT:    k_ht = sv;
            smc4_pkg::REG_GAIN_HEADING:   k_hd = sv;
            default: ;
        endcase
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Round to nearest, ties toward plus infinity.
    function longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint div_floor(longint a, longint b);
        if (a >= 0) return a / b;
        return -((-a + b - 1) / b);
    endfunction

    function longint q12_mul(longint k, longint v);
        return clip32(round_shift(k * v, 12));
    endfunction

    function longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 32;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Vectoring CORDIC: angle of (x, y) in Q16.16 radians.
    function longint vector_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < smc4_pkg::CORDIC_STEPS_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs;
                z = z + longint'(smc4_pkg::angle_entry(smc4_pkg::CI_W'(i)));
            end else begin
                x = x - ys; y = y + xs;
                z = z - longint'(smc4_pkg::angle_entry(smc4_pkg::CI_W'(i)));
            end
        end
        return z;
    endfunction

    function longint arcsine(longint a);
        longint unsigned sq;
        if (a > 65536) a = 65536;
        if (a < -65536) a = -65536;
        sq = (64'd1 << 32) - longint'(a * a);
        return vector_angle(int_sqrt(sq), a);
    endfunction

    function longint switch_term(longint k, longint s);
        longint ang;
        ang = vector_angle(65536, s);
        return q12_mul(k, round_shift(ang * 41722, 16));
    endfunction

    function longint err_rate(longint e, longint p);
        return clip32(div_floor((e - p) * 40 + 13, 26));
    endfunction

    function longint planar_cmd(longint e, inout longint p);
        longint r, lr, arg, ueq, s;
        r = err_rate(e, p);
        lr = q12_mul(lam_pl, r);
        arg = div_floor(-lr * 200 + 981, 1962);
        ueq = arcsine(arg);
        s = clip32(r + q12_mul(lam_pl, e));
        p = e;
        return clip32(ueq - switch_term(k_pl, s));
    endfunction

    function longint linear_cmd(longint e, inout longint p, input longint lam, input longint k);
        longint r, ueq, s;
        r = err_rate(e, p);
        ueq = clip32(e - q12_mul(lam, r));
        s = clip32(r + q12_mul(lam, e));
        p = e;
        return clip32(ueq - switch_term(k, s));
    endfunction

    function longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Works out the pulse word that an accepted sample must produce.
    function void note_sample(logic signed [17:0] alt, logic signed [15:0] ex,
                              logic signed [15:0] ey, logic signed [15:0] eh,
                              logic seen, logic en);
        longint ez, uz, ux, uy, uh, roll, pitch, yaw, thr;
        pulse_word_t w;
        ez = clip32(div_floor((alt_target - longint'(alt)) * 65536 + 500, 1000));
        uz = linear_cmd(ez, last_z, lam_ht, k_ht);
        uy = planar_cmd(longint'(ey) * 256, last_y);
        ux = planar_cmd(longint'(ex) * 256, last_x);
        uh = linear_cmd(longint'(eh) * 256, last_h, lam_hd, k_hd);
        roll = 1500;
        pitch = 1500;
        if (seen) begin
            roll = 1500 - round_shift(ux * 150, 16);
            pitch = 1500 + round_shift(uy * 150, 16);
        end
        yaw = limit(1500 - round_shift(uh * 90, 16), 1400, 1600);
        thr = limit(1500 + round_shift(uz * 150, 16), 1300, 1550);
        roll = limit(roll, 1300, 1700);
        pitch = limit(pitch, 1300, 1700);
        w = '0;
        if (en) begin
            w.roll = 11'(roll);
            w.pitch = 11'(pitch);
            w.thr_sent = 11'd1500;
            w.yaw = 11'(yaw);
            w.mode = 11'd1420;
        end
        w.thr_calc = 11'(thr);
        pending_pulses.push_back(w);
    endfunction

    function void check_pulses(pulse_word_t got);
        pulse_word_t exp_w;
        if (pending_pulses.size() == 0) begin
            $display("%0t: unexpected word %h", $realtime, got);
            errors++;
            return;
        end
        exp_w = pending_pulses.pop_front();
        if (got.roll != exp_w.roll) begin
            $display("%0t: roll exp %0d got %0d", $realtime, exp_w.roll, got.roll);
            errors++;
        end
        if (got.pitch != exp_w.pitch) begin
            $display("%0t: pitch exp %0d got %0d", $realtime, exp_w.pitch, got.pitch);
            errors++;
        end
        if (got.thr_sent != exp_w.thr_sent) begin
            $display("%0t: throttle_sent exp %0d got %0d", $realtime, exp_w.thr_sent,
                     got.thr_sent);
            errors++;
        end
        if (got.yaw != exp_w.yaw) begin
            $display("%0t: yaw exp %0d got %0d", $realtime, exp_w.yaw, got.yaw);
            errors++;
        end
        if (got.mode != exp_w.mode) begin
            $display("%0t: mode exp %0d got %0d", $realtime, exp_w.mode, got.mode);
            errors++;
        end
        if (got.thr_calc != exp_w.thr_calc) begin
            $display("%0t: throttle_computed exp %0d got %0d", $realtime, exp_w.thr_calc,
                     got.thr_calc);
            errors++;
        end
    endfunction
endclass

module tb_sliding_mode_four_axis_controller;
    import smc4_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [17:0] altitude_mm = '0;
    logic signed [15:0] lateral_x_error = '0;
    logic signed [15:0] lateral_y_error = '0;
    logic signed [15:0] heading_error = '0;
    logic               target_seen = 1'b0;
    logic               drive_enable = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [PULSE_W-1:0] roll_pulse, pitch_pulse, throttle_sent;
    logic [PULSE_W-1:0] yaw_pulse, mode_pulse, throttle_computed;

    // When set, both sides run at full rate with no random idling.
    bit                 no_idle = 1'b0;
    pulse_scoreboard    sb;

    // Idle margin long enough to cover one word in flight.
    localparam int DRAIN_CYCLES = 800;

    sliding_mode_four_axis_controller dut (.*);

    always #5 clk = ~clk;

    // Random back-pressure on the result side, about one cycle in three, unless no_idle is set.
    always @(posedge clk)
    begin
        out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    // Every accepted sample is handed to the predictor with the values seen before the edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_sample(altitude_mm, lateral_x_error, lateral_y_error, heading_error,
                           target_seen, drive_enable);
    end

    // Every accepted result word is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pulses({roll_pulse, pitch_pulse, throttle_sent, yaw_pulse, mode_pulse,
                             throttle_computed});
    end

    // Register write held for one edge; the caller lowers the enable after the last one.
    task automatic write_cfg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Writes every register back to back; only issued while the block is idle.
    task automatic write_all(logic [16:0] tgt, logic [15:0] lp, logic [15:0] lh,
                             logic [15:0] ld, logic [15:0] kp, logic [15:0] kh,
                             logic [15:0] kd);
        write_cfg(REG_ALT_TARGET, tgt);
        write_cfg(REG_LAMBDA_PLANAR, {1'b0, lp});
        write_cfg(REG_LAMBDA_HEIGHT, {1'b0, lh});
        write_cfg(REG_LAMBDA_HEADING, {1'b0, ld});
        write_cfg(REG_GAIN_PLANAR, {1'b0, kp});
        write_cfg(REG_GAIN_HEIGHT, {1'b0, kh});
        write_cfg(REG_GAIN_HEADING, {1'b0, kd});
        cfg_write <= 1'b0;
    endtask

    // Sends one sample word: an optional random gap, then valid held until accepted.
    // Valid is only lowered when a gap follows, so it never toggles within one step.
    task automatic send_sample(logic signed [17:0] alt, logic signed [15:0] ex,
                               logic signed [15:0] ey, logic signed [15:0] eh,
                               logic seen, logic en);
        if (!no_idle && $urandom_range(0, 99) < 33) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        in_valid <= 1'b1;
        altitude_mm <= alt;
        lateral_x_error <= ex;
        lateral_y_error <= ey;
        heading_error <= eh;
        target_seen <= seen;
        drive_enable <= en;
        do @(posedge clk); while (!in_ready);
    endtask

    // Lets every expected word come out, then gives the sequencer time to settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_pulses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random sample: mostly small errors so the rates stay in the linear range, with some
    // full-scale values that drive the rates and the arcsine argument into saturation.
    task automatic send_random(int count);
        logic signed [17:0] alt;
        logic signed [15:0] ex, ey, eh;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                alt = 18'($urandom);
                ex = 16'($urandom);
                ey = 16'($urandom);
                eh = 16'($urandom);
            end else begin
                alt = 18'(sb.alt_target) + 18'(signed'(12'($urandom)));
                ex = 16'(signed'(10'($urandom)));
                ey = 16'(signed'(10'($urandom)));
                eh = 16'(signed'(11'($urandom)));
            end
            send_sample(alt, ex, ey, eh, $urandom_range(0, 4) != 0, $urandom_range(0, 7) != 0);
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset settings: field extremes, both flags, and a large step
        // that saturates the rates and the arcsine argument.
        send_sample(18'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
        send_sample(18'sd131071, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b1);
        send_sample(-18'sd131072, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b1);
        send_sample(-18'sd131072, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b1);
        send_sample(18'sd7000, 16'sd32767, -16'sd32768, 16'sd0, 1'b0, 1'b1);
        send_sample(18'sd7000, 16'sd100, 16'sd100, 16'sd100, 1'b1, 1'b0);
        send_sample(18'sd7000, 16'sd100, 16'sd100, 16'sd100, 1'b0, 1'b0);
        send_sample(18'sd6990, -16'sd50, 16'sd40, -16'sd300, 1'b1, 1'b1);
        send_sample(18'sd7000, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
        drain();

        // Extreme settings: largest target, largest slopes and most negative gains.
        write_all(17'd131071, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_sample(18'sd131071, 16'sd1, -16'sd1, 16'sd1, 1'b1, 1'b1);
        send_sample(-18'sd131072, 16'sd32767, -16'sd32768, 16'sd32767, 1'b1, 1'b1);
        send_sample(18'sd0, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1, 1'b1);
        send_random(200);
        drain();

        // Opposite extremes: zero target, most negative slopes, largest gains.
        write_all(17'd0, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(18'sd0, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b1);
        send_sample(18'sd131071, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1, 1'b0);
        send_random(200);
        drain();

        // A stretch at full rate on both sides with the reset-like defaults.
        write_all(17'd7000, 16'd3686, 16'd2048, 16'd410, 16'hF000, 16'hF333, 16'hF800);
        no_idle = 1'b1;
        send_random(250);
        no_idle = 1'b0;
        drain();

        // Random register settings.
        for (int ph = 0; ph < 4; ph++) begin
            write_all(17'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
            send_random(140);
            drain();
        end

        if (sb.pending_pulses.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $realtime,
                     sb.pending_pulses.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog far above the slowest correct run.
    initial
    begin
        #60_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/smc4_pkg.sv
hdl/sliding_mode_four_axis_controller.sv
hdl/smc4_checker.sv
dv/tb_sliding_mode_four_axis_controller.sv
